// File: hw/rtl/wsd_pkg.sv
// ============================================================================
// wsd_pkg
// Shared types and constants of the weighted spectral difference search.
// ============================================================================
package wsd_pkg;

  // Field widths
  localparam int SUM_WIDTH    = 48;
  localparam int OFFSET_WIDTH = 24;
  localparam int BIN_WIDTH    = 12;
  localparam int ROUNDS_WIDTH = 16;
  localparam int VALUE_WIDTH  = 8;
  localparam int TERM_WIDTH   = 2 * VALUE_WIDTH;

  // Bins at or above this index never count
  localparam int MAX_BINS = 4096;

  // Register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_LOW_BIN    = 2'd0,
    REG_HIGH_BIN   = 2'd1,
    REG_MIN_ROUNDS = 2'd2
  } reg_idx_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [BIN_WIDTH-1:0]    low_bin;
    logic [BIN_WIDTH-1:0]    high_bin;
    logic [ROUNDS_WIDTH-1:0] min_rounds;
  } cfg_t;

  // One request after the input register; term is zero outside the band
  typedef struct packed {
    logic [TERM_WIDTH-1:0]   term;
    logic [OFFSET_WIDTH-1:0] offset;
    logic                    frame_end;
    logic                    cand_end;
    logic                    restart;
  } stage_t;

  // One result request
  typedef struct packed {
    logic [SUM_WIDTH-1:0]    best_sum;
    logic [OFFSET_WIDTH-1:0] best_offset;
    logic [ROUNDS_WIDTH-1:0] rounds_left;
    logic                    improved;
    logic                    skipped;
    logic [SUM_WIDTH-1:0]    cand_sum;
  } result_t;

endpackage

// File: hw/rtl/wsd_apb_regs.sv
// ============================================================================
// wsd_apb_regs
// APB register file holding the band edges and the round budget.
// ============================================================================
module wsd_apb_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output wsd_pkg::cfg_t      cfg_o
);

  logic [wsd_pkg::BIN_WIDTH-1:0]    low_bin_q;
  logic [wsd_pkg::BIN_WIDTH-1:0]    high_bin_q;
  logic [wsd_pkg::ROUNDS_WIDTH-1:0] min_rounds_q;
  logic                             wr_en;
  wsd_pkg::reg_idx_e                idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = wsd_pkg::reg_idx_e'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bin_q    <= '0;
      high_bin_q   <= '1;
      min_rounds_q <= wsd_pkg::ROUNDS_WIDTH'(8);
    end else if (wr_en) begin
      case (idx)
        wsd_pkg::REG_LOW_BIN:    low_bin_q    <= pwdata[wsd_pkg::BIN_WIDTH-1:0];
        wsd_pkg::REG_HIGH_BIN:   high_bin_q   <= pwdata[wsd_pkg::BIN_WIDTH-1:0];
        wsd_pkg::REG_MIN_ROUNDS: min_rounds_q <= pwdata[wsd_pkg::ROUNDS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      wsd_pkg::REG_LOW_BIN:    prdata = 32'(low_bin_q);
      wsd_pkg::REG_HIGH_BIN:   prdata = 32'(high_bin_q);
      wsd_pkg::REG_MIN_ROUNDS: prdata = 32'(min_rounds_q);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.low_bin    = low_bin_q;
  assign cfg_o.high_bin   = high_bin_q;
  assign cfg_o.min_rounds = min_rounds_q;

endmodule

// File: hw/rtl/wsd_search.sv
// ============================================================================
// wsd_search
// Search state: saturating accumulator, early abort, best sum and budget.
// ============================================================================
module wsd_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsd_pkg::cfg_t       cfg_i,
  input  wsd_pkg::stage_t     item_i,
  input  logic                fire_i,
  output wsd_pkg::result_t    res_o
);

  localparam int SW = wsd_pkg::SUM_WIDTH;
  localparam int OW = wsd_pkg::OFFSET_WIDTH;
  localparam int RW = wsd_pkg::ROUNDS_WIDTH;

  logic [SW-1:0] acc_q, acc_d;
  logic          abort_q, abort_d;
  logic [SW-1:0] best_q, best_d;
  logic [OW-1:0] pos_q, pos_d;
  logic [RW-1:0] budget_q, budget_d;

  logic [SW-1:0] acc_s, best_s, acc_n;
  logic [OW-1:0] pos_s, off_gap;
  logic [RW-1:0] budget_s, budget_n;
  logic          abort_s, abort_n, skipped, improved;
  logic [SW:0]   acc_sum;

  always_comb begin
    // restart clears the search before the item itself
    acc_s    = item_i.restart ? '0 : acc_q;
    abort_s  = item_i.restart ? 1'b0 : abort_q;
    best_s   = item_i.restart ? '1 : best_q;
    pos_s    = item_i.restart ? '0 : pos_q;
    budget_s = item_i.restart ? cfg_i.min_rounds : budget_q;

    skipped  = (budget_s == '0);
    acc_sum  = {1'b0, acc_s} + (SW + 1)'(item_i.term);
    acc_n    = acc_s;
    abort_n  = abort_s;
    if (!skipped && !abort_s) begin
      // saturate on carry out
      acc_n   = acc_sum[SW] ? '1 : acc_sum[SW-1:0];
      abort_n = item_i.frame_end && (acc_n > best_s);
    end

    // candidate decision
    off_gap   = (item_i.offset >= pos_s) ? item_i.offset - pos_s : pos_s - item_i.offset;
    improved  = 1'b0;
    budget_n  = budget_s;
    best_d    = best_s;
    pos_d     = pos_s;
    if (item_i.cand_end && !skipped) begin
      if (acc_n < best_s) begin
        improved = 1'b1;
        best_d   = acc_n;
        pos_d    = item_i.offset;
        budget_n = cfg_i.min_rounds;
      end else if (off_gap <= OW'(cfg_i.min_rounds)) begin
        budget_n = budget_s - RW'(1);
      end
    end
    budget_d = budget_n;
    acc_d    = item_i.cand_end ? '0 : acc_n;
    abort_d  = item_i.cand_end ? 1'b0 : abort_n;
  end

  // State update on each processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      abort_q  <= 1'b0;
      best_q   <= '1;
      pos_q    <= '0;
      budget_q <= '0;
    end else if (fire_i) begin
      acc_q    <= acc_d;
      abort_q  <= abort_d;
      best_q   <= best_d;
      pos_q    <= pos_d;
      budget_q <= budget_d;
    end
  end

  assign res_o.best_sum    = best_d;
  assign res_o.best_offset = pos_d;
  assign res_o.rounds_left = budget_n;
  assign res_o.improved    = improved;
  assign res_o.skipped     = skipped;
  assign res_o.cand_sum    = skipped ? '0 : acc_n;

endmodule

// File: hw/rtl/weighted_spectral_diff_best_match.sv
// ============================================================================
// weighted_spectral_diff_best_match
// Weighted spectral difference scoring with best-offset search.
// ============================================================================
// Usage:
//   s_axis carries one bin pair per request: ref/cand values, bin index and
//   candidate offset in tdata, candidate end on tlast, frame end and
//   restart in tuser. m_axis gives one result per candidate end: best sum,
//   best offset, rounds left and candidate sum in tdata, improved and
//   skipped flags in tuser. Other requests give no result.
//   The APB port sets the band edges and the round budget; write it only
//   while the block is idle.
//   A result is registered: its closing request lands in the input
//   register at acceptance, and the search update loads the output register
//   when that request leaves the input register. Throughput: one request
//   per cycle, set by the single multiply-accumulate and best-sum compare
//   done per cycle, while no candidate end waits behind a held result.
//   Reset clears the pipeline, sets best sum to all ones and the budget to
//   zero, so candidates are skipped until the first restart.
//   When m_axis stalls, the result holds; requests without a result keep
//   flowing, and a second candidate end waits in the input register.
// ============================================================================
module weighted_spectral_diff_best_match (
  input  logic         clk_i,
  input  logic         rst_ni,
  // {cand_offset[51:28], bin_index[27:16], cand_value[15:8], ref_value[7:0]}
  input  logic [55:0]  s_axis_tdata,
  // {restart[1], frame_end[0]}
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // {cand_sum[135:88], rounds_left[87:72], best_offset[71:48], best_sum[47:0]}
  output logic [135:0] m_axis_tdata,
  // {skipped[1], improved[0]}
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int VW = wsd_pkg::VALUE_WIDTH;
  localparam int BW = wsd_pkg::BIN_WIDTH;
  localparam int OW = wsd_pkg::OFFSET_WIDTH;

  wsd_pkg::cfg_t    cfg;
  wsd_pkg::stage_t  s1_q, s1_d;
  wsd_pkg::result_t res, out_q;
  logic             s1_valid_q, out_valid_q;
  logic             s1_fire, in_fire, res_load;

  logic signed [VW-1:0] ref_v, cand_v;
  logic signed [VW:0]   diff;
  logic [VW-1:0]        abs_diff, weight;
  logic [BW-1:0]        bin;
  logic                 in_band;

  wsd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Weighted term of the incoming pair, zero outside the band
  always_comb begin
    ref_v    = s_axis_tdata[VW-1:0];
    cand_v   = s_axis_tdata[2*VW-1:VW];
    bin      = s_axis_tdata[2*VW+BW-1:2*VW];
    diff     = {ref_v[VW-1], ref_v} - {cand_v[VW-1], cand_v};
    abs_diff = diff[VW] ? VW'(-diff) : diff[VW-1:0];
    weight   = {~ref_v[VW-1], ref_v[VW-2:0]};
    in_band  = (bin > cfg.low_bin) && (bin < cfg.high_bin) && (32'(bin) < wsd_pkg::MAX_BINS);
    s1_d.term      = in_band ? abs_diff * weight : '0;
    s1_d.offset    = s_axis_tdata[2*VW+BW+OW-1:2*VW+BW];
    s1_d.frame_end = s_axis_tuser[0];
    s1_d.restart   = s_axis_tuser[1];
    s1_d.cand_end  = s_axis_tlast;
  end

  // Handshake: a request leaves the input register unless its result
  // would overwrite a waiting one
  assign s1_fire  = s1_valid_q && (!s1_q.cand_end || !out_valid_q || m_axis_tready);
  assign res_load = s1_fire && s1_q.cand_end;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  wsd_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (s1_q),
    .fire_i (s1_fire),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.cand_sum, out_q.rounds_left, out_q.best_offset, out_q.best_sum};
  assign m_axis_tuser  = {out_q.skipped, out_q.improved};

  // Checks
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.improved && out_q.skipped))
    else $error("improved and skipped both set");

  a_skip_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.skipped) |-> (out_q.cand_sum == '0))
    else $error("skipped candidate carries a sum");

  a_improved_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.improved) |-> (out_q.best_sum == out_q.cand_sum))
    else $error("new best differs from candidate sum");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && s1_q.cand_end && out_valid_q))
    else $error("input stalled without a waiting result");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: weighted spectral difference best-match search
// Streams bin pairs through the block, runs the expected search state in
// parallel and checks each result field by field. The band edges and round
// budget are reprogrammed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [wsd_pkg::SUM_WIDTH-1:0] SUM_ALL = {wsd_pkg::SUM_WIDTH{1'b1}};

  // One bin pair as it is sent; hold makes the sender wait for all results
  typedef struct {
    logic signed [wsd_pkg::VALUE_WIDTH-1:0] ref_val;
    logic signed [wsd_pkg::VALUE_WIDTH-1:0] cand_val;
    logic [wsd_pkg::BIN_WIDTH-1:0]          bin_idx;
    logic [wsd_pkg::OFFSET_WIDTH-1:0]       offset;
    bit                                     frame_end;
    bit                                     cand_end;
    bit                                     restart;
    bit                                     hold;
  } bin_pair_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic [55:0]  s_axis_tdata  = '0;  // ref_value, cand_value, bin_index, cand_offset
  logic [1:0]   s_axis_tuser  = '0;  // frame_end, restart
  logic         s_axis_tlast  = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] m_axis_tdata;        // best_sum, best_offset, rounds_left, cand_sum
  logic [1:0]   m_axis_tuser;        // improved, skipped
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [3:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  weighted_spectral_diff_best_match i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Expected search state and its copy of the registers
  logic [wsd_pkg::BIN_WIDTH-1:0]    cfg_low    = '0;
  logic [wsd_pkg::BIN_WIDTH-1:0]    cfg_high   = 12'd4095;
  logic [wsd_pkg::ROUNDS_WIDTH-1:0] cfg_rounds = 16'd8;
  logic [wsd_pkg::SUM_WIDTH-1:0]    acc_sum    = '0;
  bit                               cand_dropped;
  logic [wsd_pkg::SUM_WIDTH-1:0]    best_total = SUM_ALL;
  logic [wsd_pkg::OFFSET_WIDTH-1:0] best_pos   = '0;
  logic [wsd_pkg::ROUNDS_WIDTH-1:0] budget_cnt = '0;

  bin_pair_t            pending_pairs[$];
  wsd_pkg::result_t     expected_results[$];
  int unsigned          mismatches;
  bit                   calm;

  // Scores one pair against the search state; returns 1 when a result is due
  function automatic bit score_pair(input bin_pair_t p, output wsd_pkg::result_t res);
    int                               diff;
    int                               weight;
    logic [wsd_pkg::SUM_WIDTH-1:0]    term;
    logic [wsd_pkg::OFFSET_WIDTH-1:0] off_gap;
    bit                               skip;
    res = '0;
    if (p.restart) begin
      best_total   = SUM_ALL;
      best_pos     = '0;
      budget_cnt   = cfg_rounds;
      acc_sum      = '0;
      cand_dropped = 1'b0;
    end
    skip = (budget_cnt == 0);
    if (!skip && !cand_dropped) begin
      if (p.bin_idx > cfg_low && p.bin_idx < cfg_high) begin
        diff = int'(p.ref_val) - int'(p.cand_val);
        if (diff < 0) diff = -diff;
        weight = int'(p.ref_val) + 128;
        term = wsd_pkg::SUM_WIDTH'(diff * weight);
        if (acc_sum > SUM_ALL - term) acc_sum = SUM_ALL;
        else acc_sum = acc_sum + term;
      end
      // early termination once a frame is already worse than the best
      if (p.frame_end && acc_sum > best_total) cand_dropped = 1'b1;
    end
    if (!p.cand_end) return 1'b0;
    res.skipped = skip;
    if (!skip) begin
      res.cand_sum = acc_sum;
      if (acc_sum < best_total) begin
        best_total   = acc_sum;
        best_pos     = p.offset;
        budget_cnt   = cfg_rounds;
        res.improved = 1'b1;
      end else begin
        off_gap = (p.offset >= best_pos) ? p.offset - best_pos : best_pos - p.offset;
        if (off_gap <= cfg_rounds) budget_cnt = budget_cnt - 1'b1;
      end
    end
    acc_sum      = '0;
    cand_dropped = 1'b0;
    res.best_sum    = best_total;
    res.best_offset = best_pos;
    res.rounds_left = budget_cnt;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: takes pairs from the pending queue, idles in random bursts
  bin_pair_t        cur_pair;
  wsd_pkg::result_t drv_res;
  int               gap_left;
  bit               drv_vld;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (score_pair(cur_pair, drv_res)) expected_results.push_back(drv_res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        drv_vld = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].hold && expected_results.size() != 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 10);
          end else begin
            cur_pair = pending_pairs.pop_front();
            s_axis_tdata <= {4'b0, cur_pair.offset, cur_pair.bin_idx,
                             cur_pair.cand_val, cur_pair.ref_val};
            s_axis_tuser <= {cur_pair.restart, cur_pair.frame_end};
            s_axis_tlast <= cur_pair.cand_end;
            drv_vld = 1'b1;
          end
        end
        s_axis_tvalid <= drv_vld;
      end
    end
  end

  // Receiver backpressure in random stall bursts
  int stall_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result monitor
  wsd_pkg::result_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with none pending: best_sum 0x%0h cand_sum 0x%0h",
               m_axis_tdata[47:0], m_axis_tdata[135:88]);
        mismatches++;
      end else begin
        mon_want = expected_results.pop_front();
        check_field("best_sum",    mon_want.best_sum,    m_axis_tdata[47:0]);
        check_field("best_offset", mon_want.best_offset, m_axis_tdata[71:48]);
        check_field("rounds_left", mon_want.rounds_left, m_axis_tdata[87:72]);
        check_field("cand_sum",    mon_want.cand_sum,    m_axis_tdata[135:88]);
        check_field("improved",    mon_want.improved,    m_axis_tuser[0]);
        check_field("skipped",     mon_want.skipped,     m_axis_tuser[1]);
      end
    end
  end

  // APB write followed by a read back of the same register
  task automatic write_register(input wsd_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] mask;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      wsd_pkg::REG_LOW_BIN: begin
        cfg_low = value[wsd_pkg::BIN_WIDTH-1:0];
        mask = 32'hFFF;
      end
      wsd_pkg::REG_HIGH_BIN: begin
        cfg_high = value[wsd_pkg::BIN_WIDTH-1:0];
        mask = 32'hFFF;
      end
      default: begin
        cfg_rounds = value[wsd_pkg::ROUNDS_WIDTH-1:0];
        mask = 32'hFFFF;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", value & mask, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_pair(input int rv, input int cv, input int bin, input int off,
                          input bit fe, input bit ce, input bit rs, input bit hold);
    bin_pair_t p;
    p.ref_val   = 8'(rv);
    p.cand_val  = 8'(cv);
    p.bin_idx   = 12'(bin);
    p.offset    = 24'(off);
    p.frame_end = fe;
    p.cand_end  = ce;
    p.restart   = rs;
    p.hold      = hold;
    pending_pairs.push_back(p);
  endtask

  // Mostly well-formed searches with random content, some loose pairs
  task automatic add_searches(input int count, input int bin_lo, input int bin_hi);
    int          made;
    int          ncand;
    int          nframes;
    int          nbins;
    int          amp;
    int          rv;
    int          cv;
    bit          first_search;
    bit          closed;
    bit          opening;
    logic [23:0] base;
    logic [23:0] off;
    made = 0;
    first_search = 1'b1;
    while (made < count) begin
      if ($urandom_range(0, 6) == 0) begin
        add_pair(int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                 $urandom_range(0, 4095), $urandom_range(0, 24'hFFFFFF),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 9) == 0, 1'b0);
        made++;
      end else begin
        base  = 24'($urandom);
        ncand = $urandom_range(3, 12);
        for (int c = 0; c < ncand; c++) begin
          if ($urandom_range(0, 5) == 0) off = base + 24'($urandom_range(0, 400));
          else off = base + 24'($urandom_range(0, 12));
          case ($urandom_range(0, 3))
            0: amp = 0;
            1: amp = 3;
            2: amp = 20;
            default: amp = 255;
          endcase
          nframes = $urandom_range(1, 3);
          closed  = ($urandom_range(0, 14) != 0);
          for (int f = 0; f < nframes; f++) begin
            nbins = $urandom_range(1, 5);
            for (int b = 0; b < nbins; b++) begin
              rv = int'($urandom_range(0, 255)) - 128;
              cv = rv + int'($urandom_range(0, 2 * amp)) - amp;
              if (cv > 127) cv = 127;
              if (cv < -128) cv = -128;
              opening = (c == 0 && f == 0 && b == 0);
              add_pair(rv, cv, $urandom_range(bin_lo, bin_hi), off, b == nbins - 1,
                       closed && b == nbins - 1 && f == nframes - 1, opening,
                       opening && (first_search || $urandom_range(0, 5) == 0));
              made++;
            end
          end
          first_search = 1'b0;
        end
      end
    end
  endtask

  // Waits until every sent pair is through and every result has arrived
  task automatic drain;
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int low, input int high, input int rounds, input int count,
                           input int bin_lo, input int bin_hi);
    write_register(wsd_pkg::REG_LOW_BIN,    {20'($urandom), 12'(low)});
    write_register(wsd_pkg::REG_HIGH_BIN,   {20'($urandom), 12'(high)});
    write_register(wsd_pkg::REG_MIN_ROUNDS, {16'($urandom), 16'(rounds)});
    add_searches(count, bin_lo, bin_hi);
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on reset settings
    add_pair(127, -128, 5, 0, 1, 1, 0, 0);              // no budget yet: skipped
    add_pair(-128, 127, 1, 24'hABCDEF, 0, 0, 1, 0);     // restart, zero weight
    add_pair(127, -128, 4094, 24'hFFFFFF, 1, 1, 0, 0);  // largest term, first best
    add_pair(0, 0, 0, 0, 1, 1, 0, 0);                   // low edge excluded, zero sum
    add_pair(127, 0, 10, 3, 1, 0, 0, 0);                // frame over best: aborted
    add_pair(127, -128, 11, 3, 0, 1, 0, 0);             // ignored, near best: decrement
    add_pair(5, 1, 4095, 1000, 1, 1, 0, 0);             // high edge excluded, far offset
    add_pair(-1, 100, 20, 7, 0, 0, 0, 0);               // partial candidate
    add_pair(0, 0, 0, 50, 1, 1, 1, 0);                  // restart drops the partial sum
    for (int i = 0; i < 9; i++)                         // run the budget down to zero
      add_pair(int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
               0, 50, 1, 1, 0, 0);
    drain();

    // Random part across band and budget settings
    run_phase(0, 4095, 8, 250, 0, 4095);
    run_phase(100, 200, 3, 200, 80, 220);
    run_phase(4095, 0, 0, 60, 0, 4095);
    run_phase(0, 0, 65535, 100, 0, 30);
    run_phase(2000, 2002, 1, 100, 1995, 2008);
    calm = 1'b1;
    run_phase(0, 4095, 5, 240, 0, 4095);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
